// File: rtl/real_fft8_halfcomplex_kernel_unit_defines.svh
// assertion macros for the eight-point real fft kernel
`ifndef REAL_FFT8_HALFCOMPLEX_KERNEL_UNIT_DEFINES_SVH
`define REAL_FFT8_HALFCOMPLEX_KERNEL_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RFFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RFFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rfft8hc_pkg.sv
// shared constants and types for the eight-point real fft kernel
package rfft8hc_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int OUT_GROWTH    = 3;
    localparam int NPOINTS       = 8;
    localparam int COEF_WIDTH    = 18;
    localparam int FRAC_BITS     = 16;
    localparam int ROUND_BIAS    = 32768;
    localparam int INV_SQRT2_Q16 = 46341;
    localparam int SQRT2_Q16     = 92682;

    typedef enum logic {
        DIR_FORWARD  = 1'b0,
        DIR_BACKWARD = 1'b1
    } t_direction;

endpackage

// File: rtl/rfft8hc_if.sv
// valid/ready channel interfaces for samples, results and configuration
interface rfft8hc_in_if #(
    parameter int SAMPLE_WIDTH = rfft8hc_pkg::SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] x0;
    logic signed [SAMPLE_WIDTH-1:0] x1;
    logic signed [SAMPLE_WIDTH-1:0] x2;
    logic signed [SAMPLE_WIDTH-1:0] x3;
    logic signed [SAMPLE_WIDTH-1:0] x4;
    logic signed [SAMPLE_WIDTH-1:0] x5;
    logic signed [SAMPLE_WIDTH-1:0] x6;
    logic signed [SAMPLE_WIDTH-1:0] x7;
    logic                           last_in;

    modport source (output valid, x0, x1, x2, x3, x4, x5, x6, x7, last_in, input ready);
    modport sink   (input valid, x0, x1, x2, x3, x4, x5, x6, x7, last_in, output ready);
endinterface

interface rfft8hc_out_if #(
    parameter int SAMPLE_WIDTH = rfft8hc_pkg::SAMPLE_WIDTH
);
    localparam int OW = SAMPLE_WIDTH + rfft8hc_pkg::OUT_GROWTH;

    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] y0;
    logic signed [OW-1:0] y1;
    logic signed [OW-1:0] y2;
    logic signed [OW-1:0] y3;
    logic signed [OW-1:0] y4;
    logic signed [OW-1:0] y5;
    logic signed [OW-1:0] y6;
    logic signed [OW-1:0] y7;
    logic                 last_out;

    modport source (output valid, y0, y1, y2, y3, y4, y5, y6, y7, last_out, input ready);
    modport sink   (input valid, y0, y1, y2, y3, y4, y5, y6, y7, last_out, output ready);
endinterface

interface rfft8hc_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, direction, input ready);
    modport sink   (input valid, direction, output ready);
endinterface

// File: rtl/real_fft8_halfcomplex_kernel_unit.sv
// eight-point real fft kernel, forward r2hc or backward hc2r, fixed point
// each input item passes the input register, then the result register, before its transfer
// throughput: one group of eight samples per cycle while the result side is ready, the
// whole transform being one combinational pass between the input and result registers
// reset: both pipeline valid flags clear and direction returns to forward
// configuration is always ready and takes effect on the next cycle
module real_fft8_halfcomplex_kernel_unit #(
    parameter int SAMPLE_WIDTH = rfft8hc_pkg::SAMPLE_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rfft8hc_in_if.sink     i_smp,
    rfft8hc_out_if.source  o_res,
    rfft8hc_cfg_if.sink    i_cfg
);
    `include "real_fft8_halfcomplex_kernel_unit_defines.svh"

    localparam int NP = rfft8hc_pkg::NPOINTS;
    localparam int OW = SAMPLE_WIDTH + rfft8hc_pkg::OUT_GROWTH;
    localparam int W  = OW + 1;
    localparam int CW = rfft8hc_pkg::COEF_WIDTH;
    localparam int PW = W + CW;

    // input stage
    logic                           r_in_valid;
    logic                           r_last;
    logic signed [SAMPLE_WIDTH-1:0] r_x [NP];

    // result stage
    logic                           r_out_valid;
    logic                           r_last_out;
    logic signed [OW-1:0]           r_y [NP];
    logic signed [OW-1:0]           n_y [NP];

    rfft8hc_pkg::t_direction        r_direction;

    logic                           w_adv;
    logic                           w_out_free;
    logic signed [W-1:0]            w_x [NP];
    logic signed [W-1:0]            w_y [NP];
    logic signed [CW-1:0]           w_coef;
    logic signed [W-1:0]            w_ma;
    logic signed [W-1:0]            w_mb;
    logic signed [PW-1:0]           w_pa;
    logic signed [PW-1:0]           w_pb;
    logic signed [W-1:0]            w_p;
    logic signed [W-1:0]            w_q;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_smp.ready = !r_in_valid || w_out_free;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= rfft8hc_pkg::DIR_FORWARD;
        end else if (i_cfg.valid) begin
            r_direction <= rfft8hc_pkg::t_direction'(i_cfg.direction);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_x[0] <= i_smp.x0;
            r_x[1] <= i_smp.x1;
            r_x[2] <= i_smp.x2;
            r_x[3] <= i_smp.x3;
            r_x[4] <= i_smp.x4;
            r_x[5] <= i_smp.x5;
            r_x[6] <= i_smp.x6;
            r_x[7] <= i_smp.x7;
            r_last <= i_smp.last_in;
        end
    end

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            w_x[i] = W'(r_x[i]);
        end
    end

    // two shared constant multipliers, operands picked by direction
    always_comb begin
        case (r_direction)
            rfft8hc_pkg::DIR_FORWARD: begin
                w_coef = CW'(rfft8hc_pkg::INV_SQRT2_Q16);
                w_ma   = w_x[3] - w_x[7];
                w_mb   = w_x[3] + w_x[7];
            end
            rfft8hc_pkg::DIR_BACKWARD: begin
                w_coef = CW'(rfft8hc_pkg::SQRT2_Q16);
                w_ma   = w_x[1] - w_x[5];
                w_mb   = w_x[2] + w_x[6];
            end
            default: begin
                w_coef = CW'(rfft8hc_pkg::INV_SQRT2_Q16);
                w_ma   = w_x[3] - w_x[7];
                w_mb   = w_x[3] + w_x[7];
            end
        endcase
    end

    // round half up: floor((c*v + half) / 2^16)
    assign w_pa = PW'(w_coef) * PW'(w_ma) + PW'(rfft8hc_pkg::ROUND_BIAS);
    assign w_pb = PW'(w_coef) * PW'(w_mb) + PW'(rfft8hc_pkg::ROUND_BIAS);
    assign w_p  = W'(w_pa >>> rfft8hc_pkg::FRAC_BITS);
    assign w_q  = W'(w_pb >>> rfft8hc_pkg::FRAC_BITS);

    always_comb begin
        case (r_direction)
            rfft8hc_pkg::DIR_FORWARD: begin
                w_y[0] = w_x[0] + w_x[4] + w_x[2] + w_x[6];
                w_y[1] = w_x[1] + w_p;
                w_y[2] = -w_x[5] - w_q;
                w_y[3] = w_x[0] - w_x[4];
                w_y[4] = w_x[6] - w_x[2];
                w_y[5] = w_x[1] - w_p;
                w_y[6] = w_x[5] - w_q;
                w_y[7] = w_x[0] + w_x[4] - w_x[2] - w_x[6];
            end
            rfft8hc_pkg::DIR_BACKWARD: begin
                w_y[0] = w_x[0] + w_x[7] + (w_x[3] <<< 1);
                w_y[1] = (w_x[1] + w_x[5]) <<< 1;
                w_y[2] = w_x[0] - w_x[7] - (w_x[4] <<< 1);
                w_y[3] = w_p - w_q;
                w_y[4] = w_x[0] + w_x[7] - (w_x[3] <<< 1);
                w_y[5] = (w_x[6] - w_x[2]) <<< 1;
                w_y[6] = w_x[0] - w_x[7] + (w_x[4] <<< 1);
                w_y[7] = -w_p - w_q;
            end
            default: begin
                for (int i = 0; i < NP; i++) begin
                    w_y[i] = '0;
                end
            end
        endcase
    end

    // saturate to the output range when the top two bits disagree
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            if (w_y[i][W-1] != w_y[i][W-2]) begin
                n_y[i] = {w_y[i][W-1], {(OW-1){~w_y[i][W-1]}}};
            end else begin
                n_y[i] = w_y[i][OW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_y        <= n_y;
            r_last_out <= r_last;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.y0       = r_y[0];
    assign o_res.y1       = r_y[1];
    assign o_res.y2       = r_y[2];
    assign o_res.y3       = r_y[3];
    assign o_res.y4       = r_y[4];
    assign o_res.y5       = r_y[5];
    assign o_res.y6       = r_y[6];
    assign o_res.y7       = r_y[7];
    assign o_res.last_out = r_last_out;

    `RFFT_ASSERT_NEXT(a_in_capture, i_clk, i_rst_n, i_smp.valid && i_smp.ready, r_in_valid,
        "input transfer did not fill the input stage")
    `RFFT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_out_free, r_in_valid,
        "input stage dropped an item while the result stage was full")
    `RFFT_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, w_adv, o_res.valid,
        "advanced item did not reach the result stage")
    `RFFT_ASSERT_NEXT(a_last_follow, i_clk, i_rst_n, w_adv, o_res.last_out == $past(r_last),
        "last flag lost between stages")
    `RFFT_ASSERT_NOW(a_ready_path, i_clk, i_rst_n, r_in_valid && o_res.valid && !o_res.ready,
        !i_smp.ready, "input accepted while both stages were full")

endmodule
